### src/three_channel_window_average_scaler_core_defines.svh
// Assertion macros used by the core RTL file of the window average scaler.
`ifndef THREE_CHANNEL_WINDOW_AVERAGE_SCALER_CORE_DEFINES_SVH
`define THREE_CHANNEL_WINDOW_AVERAGE_SCALER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TCWAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCWAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tcwas_pkg.sv
package tcwas_pkg;

    // Default parameter values.
    localparam int WINDOW_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths.
    localparam int GAIN_W    = 24;
    localparam int OFFSET_W  = 16;
    localparam int OUT_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = GAIN_W;

    // Fraction bits dropped after the gain multiply (Q8.16, and Q12.4 times Q8.16).
    localparam int VOLT_FRAC = 16;
    localparam int IOUT_FRAC = 20;

    // Fraction bits of the current mean before the offset subtract.
    localparam int IOUT_MEAN_FRAC = 4;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_VIN_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IOUT_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOUT_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IOUT_OFFSET = 2'd3;

    // Register reset values.
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd65536;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd0;

endpackage

### src/tcwas_if.sv
interface tcwas_in_if #(
    parameter int SAMPLE_BITS = tcwas_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_vin;
    logic [SAMPLE_BITS-1:0] sample_iout;
    logic [SAMPLE_BITS-1:0] sample_vout;

    modport source (output valid, output sample_vin, output sample_iout,
                    output sample_vout, input ready);
    modport sink   (input valid, input sample_vin, input sample_iout,
                    input sample_vout, output ready);
endinterface

interface tcwas_out_if;
    import tcwas_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] vin_value;
    logic [OUT_W-1:0] iout_value;
    logic [OUT_W-1:0] vout_value;
    logic             iout_clamped;

    modport source (output valid, output vin_value, output iout_value,
                    output vout_value, output iout_clamped, input ready);
    modport sink   (input valid, input vin_value, input iout_value,
                    input vout_value, input iout_clamped, output ready);
endinterface

### src/tcwas_hist_ram.sv
module tcwas_hist_ram #(
    parameter int DEPTH = tcwas_pkg::WINDOW_DEF,
    parameter int WIDTH = 3 * tcwas_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-before-write: the read returns the entry as it was before this write.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/three_channel_window_average_scaler_core.sv
// Three-channel window average scaler.
// i_in carries one set of three raw ADC samples per transfer (input voltage,
// output current, output voltage). o_out returns one result per accepted set:
// each channel's mean over the last WINDOW sets times its Q8.16 gain; the
// current mean is first reduced by the Q12.4 offset and clamped at zero, with
// iout_clamped set when that happens. Gains and the offset are written through
// the i_cfg_* port; the user must write them only while no transfer is in
// flight, as the block does not enforce it. The input transfer loads stage one
// beside the history RAM read; the running sum and mean, the gain multiply and
// the shift and saturate each follow in a registered stage up to o_out.valid.
// One set can be accepted every cycle unless a receiver stall has filled every
// stage; the single-port history RAM is read and written at the same address
// in the accept cycle, so one access per set sets that rate.
// Reset clears the sums, the write position, the gains to 1.0 and the offset
// to zero. The history RAM is not cleared: a fill flag makes entries read as
// zero until the window has wrapped once, so no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling, so up to three more sets are taken before
// i_in.ready drops.
`include "three_channel_window_average_scaler_core_defines.svh"

module three_channel_window_average_scaler_core #(
    parameter int WINDOW      = tcwas_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tcwas_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tcwas_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tcwas_pkg::CFG_W-1:0]           i_cfg_data,
    tcwas_in_if.sink                              i_in,
    tcwas_out_if.source                           o_out
);
    import tcwas_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SH    = $clog2(WINDOW);
    localparam int SW    = SB + SH;
    localparam int MW    = SB + IOUT_MEAN_FRAC;
    localparam int DW    = (MW > OFFSET_W) ? MW : OFFSET_W;
    localparam int PV    = SB + GAIN_W;
    localparam int PI    = DW + GAIN_W;
    localparam int RAM_W = 3 * SB;
    localparam logic [SH-1:0] POS_LAST = SH'(WINDOW - 1);

    // Configuration registers.
    logic [GAIN_W-1:0]   r_vin_gain;
    logic [GAIN_W-1:0]   r_iout_gain;
    logic [GAIN_W-1:0]   r_vout_gain;
    logic [OFFSET_W-1:0] r_iout_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vin_gain    <= GAIN_RESET;
            r_iout_gain   <= GAIN_RESET;
            r_vout_gain   <= GAIN_RESET;
            r_iout_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VIN_GAIN:    r_vin_gain    <= i_cfg_data;
                CFG_IOUT_GAIN:   r_iout_gain   <= i_cfg_data;
                CFG_VOUT_GAIN:   r_vout_gain   <= i_cfg_data;
                CFG_IOUT_OFFSET: r_iout_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables. Each stage moves when it is empty or the next one moves,
    // so bubbles collapse and the input is held off only when every stage
    // holds a set.
    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, en_o, accept;

    assign en_o   = !r_vo || o_out.ready;
    assign en3    = !r_v3 || en_o;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_in.valid && en1;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= accept;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en_o) r_vo <= r_v3;
        end
    end

    // Circular write position and fill flag. Until the window has wrapped once
    // the entry being replaced was never written and counts as zero.
    logic [SH-1:0] r_wr_pos;
    logic          r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_full   <= 1'b0;
        end else if (accept) begin
            r_wr_pos <= r_wr_pos + 1'b1;
            if (r_wr_pos == POS_LAST) begin
                r_full <= 1'b1;
            end
        end
    end

    // History RAM: one word holds the three samples of one set.
    logic [RAM_W-1:0] ram_rdata;

    tcwas_hist_ram #(
        .DEPTH (WINDOW),
        .WIDTH (RAM_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (r_wr_pos),
        .i_wdata ({i_in.sample_vout, i_in.sample_iout, i_in.sample_vin}),
        .o_rdata (ram_rdata)
    );

    // Stage 1: new samples wait beside the RAM read of the entry they replace.
    logic [SB-1:0] r_s1_vin, r_s1_iout, r_s1_vout;
    logic          r_s1_old_ok;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_vin    <= i_in.sample_vin;
            r_s1_iout   <= i_in.sample_iout;
            r_s1_vout   <= i_in.sample_vout;
            r_s1_old_ok <= r_full;
        end
    end

    logic [SB-1:0] old_vin, old_iout, old_vout;

    assign old_vin  = r_s1_old_ok ? ram_rdata[SB-1:0]      : '0;
    assign old_iout = r_s1_old_ok ? ram_rdata[2*SB-1:SB]   : '0;
    assign old_vout = r_s1_old_ok ? ram_rdata[3*SB-1:2*SB] : '0;

    // Running sums, updated once per set as it leaves stage 1.
    logic [SW-1:0] r_sum_vin, r_sum_iout, r_sum_vout;
    logic [SW-1:0] n_sum_vin, n_sum_iout, n_sum_vout;

    assign n_sum_vin  = r_sum_vin  - SW'(old_vin)  + SW'(r_s1_vin);
    assign n_sum_iout = r_sum_iout - SW'(old_iout) + SW'(r_s1_iout);
    assign n_sum_vout = r_sum_vout - SW'(old_vout) + SW'(r_s1_vout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vin  <= '0;
            r_sum_iout <= '0;
            r_sum_vout <= '0;
        end else if (en2 && r_v1) begin
            r_sum_vin  <= n_sum_vin;
            r_sum_iout <= n_sum_iout;
            r_sum_vout <= n_sum_vout;
        end
    end

    // Means. The current mean keeps four fraction bits to line up with the
    // Q12.4 offset; a negative difference is forced to zero and flagged.
    logic [SW+IOUT_MEAN_FRAC-1:0] iout_sum_q4;
    logic [MW-1:0]                mean_iout_q4;
    logic [DW-1:0]                mean_iout_ext, offset_ext;
    logic                         iout_neg;

    assign iout_sum_q4   = {n_sum_iout, {IOUT_MEAN_FRAC{1'b0}}};
    assign mean_iout_q4  = MW'(iout_sum_q4 >> SH);
    assign mean_iout_ext = DW'(mean_iout_q4);
    assign offset_ext    = DW'(r_iout_offset);
    assign iout_neg      = mean_iout_ext < offset_ext;

    logic [SB-1:0] r_m2_vin, r_m2_vout;
    logic [DW-1:0] r_d2_iout;
    logic          r_f2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_m2_vin  <= SB'(n_sum_vin >> SH);
            r_m2_vout <= SB'(n_sum_vout >> SH);
            r_d2_iout <= iout_neg ? '0 : (mean_iout_ext - offset_ext);
            r_f2      <= iout_neg;
        end
    end

    // Stage 3: one gain multiply per channel.
    logic [PV-1:0] r_p3_vin, r_p3_vout;
    logic [PI-1:0] r_p3_iout;
    logic          r_f3;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_p3_vin  <= PV'(r_m2_vin)  * PV'(r_vin_gain);
            r_p3_vout <= PV'(r_m2_vout) * PV'(r_vout_gain);
            r_p3_iout <= PI'(r_d2_iout) * PI'(r_iout_gain);
            r_f3      <= r_f2;
        end
    end

    // Output stage: drop the fraction bits and saturate to the field width.
    logic [PV-1:0] scaled_vin, scaled_vout;
    logic [PI-1:0] scaled_iout;

    assign scaled_vin  = r_p3_vin  >> VOLT_FRAC;
    assign scaled_vout = r_p3_vout >> VOLT_FRAC;
    assign scaled_iout = r_p3_iout >> IOUT_FRAC;

    logic [OUT_W-1:0] r_vin_value, r_iout_value, r_vout_value;
    logic             r_iout_clamped;

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_vin_value    <= (scaled_vin > PV'(OUT_MAX)) ? OUT_MAX
                                                          : scaled_vin[OUT_W-1:0];
            r_vout_value   <= (scaled_vout > PV'(OUT_MAX)) ? OUT_MAX
                                                           : scaled_vout[OUT_W-1:0];
            r_iout_value   <= (scaled_iout > PI'(OUT_MAX)) ? OUT_MAX
                                                           : scaled_iout[OUT_W-1:0];
            r_iout_clamped <= r_f3;
        end
    end

    assign o_out.valid        = r_vo;
    assign o_out.vin_value    = r_vin_value;
    assign o_out.iout_value   = r_iout_value;
    assign o_out.vout_value   = r_vout_value;
    assign o_out.iout_clamped = r_iout_clamped;

    // A clamped current result always carries a zero value.
    `TCWAS_ASSERT_IMP(a_clamp_zero, i_clk, i_rst_n,
                      o_out.valid && o_out.iout_clamped, o_out.iout_value == '0,
                      "clamped current result is not zero")

    // Input is held off only when every stage holds a set.
    `TCWAS_ASSERT_IMP(a_ready_full, i_clk, i_rst_n,
                      !i_in.ready, r_v1 && r_v2 && r_v3 && r_vo,
                      "input stalled with an empty stage")

    // Accepting into the last window slot marks the history as filled.
    `TCWAS_ASSERT_NXT(a_fill_set, i_clk, i_rst_n,
                      accept && (r_wr_pos == POS_LAST), r_full,
                      "fill flag not set after window wrap")

    // Once filled, the history stays filled until reset.
    `TCWAS_ASSERT_NXT(a_fill_hold, i_clk, i_rst_n, r_full, r_full,
                      "fill flag dropped without reset")

endmodule
